// File: rtl/irs_pkg.sv
package irs_pkg;

    // Fixed field widths of the command and result beats
    localparam int DATA_W  = 32;
    localparam int FUNC_W  = 2;
    localparam int INDEX_W = 7;
    localparam int COUNT_W = 7;

    // Command codes
    localparam logic [FUNC_W-1:0] CMD_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] CMD_READ   = 2'd2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // One result beat as it leaves the sequencer
    typedef struct packed {
        logic signed [DATA_W-1:0]  read_value;
        t_status                   status;
        logic        [COUNT_W-1:0] count;
        logic                      empty_res;
    } t_result;

endpackage

// File: rtl/irs_ram.sv
module irs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one read port with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/irs_seq.sv
module irs_seq #(
    parameter int DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [irs_pkg::FUNC_W-1:0]      i_func,
    input  logic signed [irs_pkg::DATA_W-1:0] i_value,
    input  logic [irs_pkg::INDEX_W-1:0]     i_index,
    output logic                            o_valid,
    output irs_pkg::t_result                o_res,
    output logic                            o_ram_we,
    output logic [$clog2(DEPTH)-1:0]        o_ram_waddr,
    output logic [irs_pkg::DATA_W-1:0]      o_ram_wdata,
    output logic [$clog2(DEPTH)-1:0]        o_ram_raddr,
    input  logic [irs_pkg::DATA_W-1:0]      i_ram_rdata
);
    import irs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;

    typedef enum logic [4:0] {
        S_IDLE     = 5'b00001,
        S_RDATA    = 5'b00010,
        S_SHIFT_RD = 5'b00100,
        S_SHIFT_WR = 5'b01000,
        S_DONE     = 5'b10000
    } t_state;

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_ptr, n_ptr;
    logic signed [DATA_W-1:0] r_rd, n_rd;
    t_status                  r_status, n_status;

    logic [AW-1:0] ptr_inc;
    logic [IW-1:0] idx_ext;
    logic [IW-1:0] cnt_ext;
    logic          in_range;
    logic          is_last;
    logic          full;

    // Shared pointer step and index compares
    assign ptr_inc  = r_ptr + AW'(1);
    assign idx_ext  = IW'(i_index);
    assign cnt_ext  = IW'(r_count);
    assign in_range = idx_ext < cnt_ext;
    assign is_last  = (idx_ext + IW'(1)) == cnt_ext;
    assign full     = r_count == CW'(DEPTH);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_rd        = r_rd;
        n_status    = r_status;
        o_ram_we    = 1'b0;
        o_ram_waddr = r_ptr;
        o_ram_wdata = i_ram_rdata;
        o_ram_raddr = ptr_inc;
        unique case (r_state)
            S_IDLE: begin
                o_ram_raddr = AW'(i_index);
                if (start) begin
                    n_rd     = '0;
                    n_status = ST_OK;
                    n_state  = S_DONE;
                    unique case (i_func)
                        CMD_PUSH: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = AW'(r_count);
                                o_ram_wdata = $unsigned(i_value);
                                n_count     = r_count + CW'(1);
                            end
                        end
                        CMD_REMOVE: begin
                            if (!in_range) begin
                                n_status = ST_RANGE;
                            end else if (is_last) begin
                                n_count = r_count - CW'(1);
                            end else begin
                                n_ptr   = AW'(i_index);
                                n_state = S_SHIFT_RD;
                            end
                        end
                        CMD_READ: begin
                            if (!in_range) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_state = S_RDATA;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RDATA: begin
                n_rd    = $signed(i_ram_rdata);
                n_state = S_DONE;
            end
            S_SHIFT_RD: begin
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                // move entry ptr+1 down to ptr
                o_ram_we = 1'b1;
                n_ptr    = ptr_inc;
                if ((CW'(ptr_inc) + CW'(1)) == r_count) begin
                    n_count = r_count - CW'(1);
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_rd     <= n_rd;
        r_status <= n_status;
    end

    assign busy               = r_state != S_IDLE;
    assign o_valid            = r_state == S_DONE;
    assign o_res.read_value   = r_rd;
    assign o_res.status       = r_status;
    assign o_res.count        = COUNT_W'(r_count);
    assign o_res.empty_res    = r_count == '0;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_write_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (CW'(o_ram_waddr) <= r_count))
        else $error("write beyond top of stack");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_func == CMD_PUSH && !full)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow the stack");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (r_state == S_IDLE))
        else $error("result strobe longer than one cycle");
`endif

endmodule

// File: rtl/indexed_removal_stack_top.sv
// Stack of signed 32-bit words with removal at any index.
// Command channel: drive start with i_func, i_value and i_index; a command
// beat is taken at a clock edge where start is high and busy is low.
// i_func: push, remove at index, read at index. Unused codes do nothing.
// Result channel: o_valid is high for exactly one cycle with o_read_value,
// o_status, o_count and o_empty_res; the receiver must take it then, it
// cannot stall the block.
// Path from the accepting edge to the result strobe:
//   push, out-of-range, unused code, remove of the top entry: direct
//   read in range: via a read-data state (registered entry store read)
//   remove at index k: via the shift loop over all entries above k
// The remove loop moves one entry per pass through its read and write
// states, using the single read and write port of the entry store; busy
// stays high meanwhile. A new command is taken the cycle after the strobe,
// so no command is taken before the last result is out.
// Reset (synchronous, active low) empties the stack; stored words are not
// cleared and no clearing pass is needed.
module indexed_removal_stack_top #(
    parameter int DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [irs_pkg::FUNC_W-1:0]        i_func,
    input  logic signed [irs_pkg::DATA_W-1:0] i_value,
    input  logic [irs_pkg::INDEX_W-1:0]       i_index,
    output logic                              o_valid,
    output logic signed [irs_pkg::DATA_W-1:0] o_read_value,
    output logic [1:0]                        o_status,
    output logic [irs_pkg::COUNT_W-1:0]       o_count,
    output logic                              o_empty_res
);
    import irs_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_result          res;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [DATA_W-1:0] ram_rdata;

    // Command sequencer
    irs_seq #(
        .DEPTH (DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (i_func),
        .i_value     (i_value),
        .i_index     (i_index),
        .o_valid     (o_valid),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    // Entry store
    irs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_read_value = res.read_value;
    assign o_status     = res.status;
    assign o_count      = res.count;
    assign o_empty_res  = res.empty_res;

endmodule
